### rtl/lzh_pkg.sv
package lzh_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int OUT_W           = 32;

    localparam int LEN_BASE    = 256;
    localparam int SYM_DEPTH   = 256 + 256 + 1;
    localparam int SYM_END     = SYM_DEPTH - 1;
    localparam int SYM_AW      = $clog2(SYM_DEPTH);

    localparam int NIB_W       = 4;
    localparam int NIB_ENTRIES = 16;
    localparam int NIB_TABLES  = 4;
    localparam int NIB_DEPTH   = NIB_ENTRIES * NIB_TABLES;
    localparam int NIB_AW      = $clog2(NIB_DEPTH);
    localparam int STEP_W      = $clog2(NIB_TABLES);

    typedef enum logic [1:0] {
        CMD_LITERAL = 2'd0,
        CMD_MATCH   = 2'd1,
        CMD_END     = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_LEN  = 2'd1,
        STAT_BAD_DIST = 2'd2,
        STAT_BAD_ADDR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        TAB_SYMBOL = 3'd0,
        TAB_NIB0   = 3'd1,
        TAB_NIB1   = 3'd2,
        TAB_NIB2   = 3'd3,
        TAB_NIB3   = 3'd4
    } table_t;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

endpackage

### rtl/lzh_count_mem.sv
module lzh_count_mem #(
    parameter int WIDTH = lzh_pkg::COUNT_WIDTH_DEF,
    parameter int DEPTH = lzh_pkg::SYM_DEPTH
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/lz_token_symbol_histogram.sv
// Symbol histogram of an LZ token stream, kept for later Huffman table building.
// Counts live in two single-port-read memories: a 513-entry symbol table (literal
// bytes, match lengths 1..255 at 256 + length, end marker at 512) and a 64-entry
// table holding the four 16-entry distance nibble tables. Counts saturate at
// all ones of COUNT_WIDTH bits; a read returns the count clamped to 32 bits.
// After reset the block clears both tables with in_stall high. One transaction at
// a time, each a read-modify-write via the registered read port (reads only read):
// literal, end and read commands pass read, update and response, a legal match
// runs read and update per nibble table (four updates through the single nibble
// port), a rejected match or bad address goes straight to response; a finished
// result waits in the output register while the next transaction is accepted.
module lz_token_symbol_histogram #(
    parameter int COUNT_WIDTH = lzh_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  literal_byte,
    input  logic [7:0]  match_length,
    input  logic [15:0] match_distance,
    input  logic [2:0]  read_table,
    input  logic [9:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] read_count
);

    localparam int SYM_AW = lzh_pkg::SYM_AW;
    localparam int NIB_AW = lzh_pkg::NIB_AW;
    localparam int STEP_W = lzh_pkg::STEP_W;
    localparam int NIB_W  = lzh_pkg::NIB_W;
    localparam int OUT_W  = lzh_pkg::OUT_W;

    lzh_pkg::state_t state_reg, state_next;
    logic [SYM_AW-1:0] clr_cnt_reg, clr_cnt_next;
    lzh_pkg::cmd_t     op_reg, op_next;
    logic [SYM_AW-1:0] sym_addr_reg, sym_addr_next;
    logic [15:0]       dist_reg, dist_next;
    logic [NIB_AW-1:0] nib_rd_addr_reg, nib_rd_addr_next;
    logic              rd_sym_reg, rd_sym_next;
    logic [STEP_W-1:0] step_reg, step_next;
    lzh_pkg::status_t  res_status_reg, res_status_next;
    logic [OUT_W-1:0]  res_count_reg, res_count_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [OUT_W-1:0]  out_count_reg, out_count_next;

    logic                   sym_rd_en, sym_wr_en, nib_rd_en, nib_wr_en;
    logic [SYM_AW-1:0]      sym_wr_addr;
    logic [NIB_AW-1:0]      nib_addr, nib_wr_addr;
    logic [COUNT_WIDTH-1:0] sym_rd_data, nib_rd_data, sym_wr_data, nib_wr_data;
    logic [COUNT_WIDTH-1:0] sym_inc, nib_inc, rd_value;
    logic [OUT_W-1:0]       rd_clamped;
    logic                   accept, out_free, read_ok;
    lzh_pkg::cmd_t          cmd_in;

    assign cmd_in   = lzh_pkg::cmd_t'(command);
    assign accept   = in_valid && (state_reg == lzh_pkg::S_IDLE);
    assign in_stall = (state_reg != lzh_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign sym_inc  = (&sym_rd_data) ? sym_rd_data : sym_rd_data + 1'b1;
    assign nib_inc  = (&nib_rd_data) ? nib_rd_data : nib_rd_data + 1'b1;
    assign rd_value = rd_sym_reg ? sym_rd_data : nib_rd_data;

    generate
        if (COUNT_WIDTH > OUT_W)
        begin : g_clamp
            assign rd_clamped = (|rd_value[COUNT_WIDTH-1:OUT_W]) ? '1 : rd_value[OUT_W-1:0];
        end
        else
        begin : g_extend
            assign rd_clamped = OUT_W'(rd_value);
        end
    endgenerate

    // match: one nibble table per step, table number in the upper address bits
    assign nib_addr = (op_reg == lzh_pkg::CMD_MATCH)
                    ? {step_reg, dist_reg[{step_reg, 2'b00} +: NIB_W]}
                    : nib_rd_addr_reg;

    always_comb
    begin
        read_ok = 1'b0;
        if (read_table == lzh_pkg::TAB_SYMBOL)
        begin
            read_ok = (read_index < SYM_AW'(lzh_pkg::SYM_DEPTH));
        end
        else if (read_table >= lzh_pkg::TAB_NIB0 && read_table <= lzh_pkg::TAB_NIB3)
        begin
            read_ok = (read_index < SYM_AW'(lzh_pkg::NIB_ENTRIES));
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        op_next          = op_reg;
        sym_addr_next    = sym_addr_reg;
        dist_next        = dist_reg;
        nib_rd_addr_next = nib_rd_addr_reg;
        rd_sym_next      = rd_sym_reg;
        step_next        = step_reg;
        res_status_next  = res_status_reg;
        res_count_next   = res_count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        sym_rd_en        = 1'b0;
        nib_rd_en        = 1'b0;
        sym_wr_en        = 1'b0;
        nib_wr_en        = 1'b0;
        sym_wr_addr      = sym_addr_reg;
        nib_wr_addr      = nib_addr;
        sym_wr_data      = sym_inc;
        nib_wr_data      = nib_inc;

        unique case (state_reg)
            lzh_pkg::S_CLEAR:
            begin
                sym_wr_en   = 1'b1;
                sym_wr_addr = clr_cnt_reg;
                sym_wr_data = '0;
                nib_wr_en   = (clr_cnt_reg < SYM_AW'(lzh_pkg::NIB_DEPTH));
                nib_wr_addr = clr_cnt_reg[NIB_AW-1:0];
                nib_wr_data = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SYM_AW'(lzh_pkg::SYM_END))
                begin
                    state_next = lzh_pkg::S_IDLE;
                end
            end
            lzh_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next          = cmd_in;
                    dist_next        = match_distance;
                    step_next        = '0;
                    res_status_next  = lzh_pkg::STAT_OK;
                    res_count_next   = '0;
                    rd_sym_next      = (read_table == lzh_pkg::TAB_SYMBOL);
                    nib_rd_addr_next = {STEP_W'(read_table - lzh_pkg::TAB_NIB0),
                                        read_index[NIB_W-1:0]};
                    state_next       = lzh_pkg::S_READ;
                    unique case (cmd_in)
                        lzh_pkg::CMD_LITERAL:
                        begin
                            sym_addr_next = SYM_AW'(literal_byte);
                        end
                        lzh_pkg::CMD_MATCH:
                        begin
                            sym_addr_next = SYM_AW'(lzh_pkg::LEN_BASE) + SYM_AW'(match_length);
                            if (match_length == '0)
                            begin
                                res_status_next = lzh_pkg::STAT_BAD_LEN;
                                state_next      = lzh_pkg::S_RESP;
                            end
                            else if (match_distance == '0)
                            begin
                                res_status_next = lzh_pkg::STAT_BAD_DIST;
                                state_next      = lzh_pkg::S_RESP;
                            end
                        end
                        lzh_pkg::CMD_END:
                        begin
                            sym_addr_next = SYM_AW'(lzh_pkg::SYM_END);
                        end
                        lzh_pkg::CMD_READ:
                        begin
                            sym_addr_next = read_index;
                            if (!read_ok)
                            begin
                                res_status_next = lzh_pkg::STAT_BAD_ADDR;
                                state_next      = lzh_pkg::S_RESP;
                            end
                        end
                        default:
                        begin
                            sym_addr_next = sym_addr_reg;
                        end
                    endcase
                end
            end
            lzh_pkg::S_READ:
            begin
                sym_rd_en  = 1'b1;
                nib_rd_en  = 1'b1;
                state_next = lzh_pkg::S_UPDATE;
            end
            lzh_pkg::S_UPDATE:
            begin
                state_next = lzh_pkg::S_RESP;
                unique case (op_reg)
                    lzh_pkg::CMD_LITERAL,
                    lzh_pkg::CMD_END:
                    begin
                        sym_wr_en = 1'b1;
                    end
                    lzh_pkg::CMD_MATCH:
                    begin
                        // length symbol is bumped once, on the first nibble step
                        sym_wr_en = (step_reg == '0);
                        nib_wr_en = 1'b1;
                        step_next = step_reg + 1'b1;
                        if (step_reg != STEP_W'(lzh_pkg::NIB_TABLES - 1))
                        begin
                            state_next = lzh_pkg::S_READ;
                        end
                    end
                    lzh_pkg::CMD_READ:
                    begin
                        res_count_next = rd_clamped;
                    end
                    default:
                    begin
                        res_count_next = res_count_reg;
                    end
                endcase
            end
            lzh_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_count_next  = res_count_reg;
                    state_next      = lzh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lzh_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzh_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        sym_addr_reg    <= sym_addr_next;
        dist_reg        <= dist_next;
        nib_rd_addr_reg <= nib_rd_addr_next;
        rd_sym_reg      <= rd_sym_next;
        step_reg        <= step_next;
        res_status_reg  <= res_status_next;
        res_count_reg   <= res_count_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

    lzh_count_mem #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (lzh_pkg::SYM_DEPTH)
    ) u_sym_mem (
        .clk     (clk),
        .rd_en   (sym_rd_en),
        .rd_addr (sym_addr_reg),
        .rd_data (sym_rd_data),
        .wr_en   (sym_wr_en),
        .wr_addr (sym_wr_addr),
        .wr_data (sym_wr_data)
    );

    lzh_count_mem #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (lzh_pkg::NIB_DEPTH)
    ) u_nib_mem (
        .clk     (clk),
        .rd_en   (nib_rd_en),
        .rd_addr (nib_addr),
        .rd_data (nib_rd_data),
        .wr_en   (nib_wr_en),
        .wr_addr (nib_wr_addr),
        .wr_data (nib_wr_data)
    );

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_count = out_count_reg;

endmodule
